// ===== design/ipd_pkg.sv =====
// Shared types, widths and constants for the insulation monitor PWM decoder.
// Used by ipd_div, ipd_out and the top level; depends on nothing else.
package ipd_pkg;

  // Capture width and the widths that follow from it
  localparam int CAPTURE_BITS = 16;
  localparam int VAL_W        = CAPTURE_BITS + 2;   // capture in microseconds
  localparam int DIVD_W       = VAL_W + 14;         // 10000 * high time
  localparam int CNT_W        = $clog2(DIVD_W);

  localparam int TIME_W       = 48;
  localparam int HOLD_W       = 20;
  localparam int FAULT_W      = 16;
  localparam int RES_W        = 16;
  localparam int CODE_W       = 4;
  localparam int LEN_W        = 2;
  localparam int ID_W         = 29;
  localparam int R_W          = 26;                 // signed resistance before clamping
  localparam int ACT_W        = 2;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 20;
  localparam int CAP_FIELD_W  = 16;                 // capture_count field in tdata
  localparam int IN_TDATA_W   = CAP_FIELD_W + TIME_W;
  localparam int OUT_TDATA_W  = 56;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOLDOFF = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAULT   = 2'd1;

  localparam logic [HOLD_W-1:0]  HOLDOFF_RST = 20'd90000;
  localparam logic [FAULT_W-1:0] FAULT_RST   = 16'd100;

  localparam logic [ID_W-1:0] HDR_BASE = 29'h19690908;

  // Status codes
  localparam logic [CODE_W-1:0] CODE_NONE      = 4'd0;
  localparam logic [CODE_W-1:0] CODE_10HZ      = 4'd1;
  localparam logic [CODE_W-1:0] CODE_20HZ      = 4'd3;
  localparam logic [CODE_W-1:0] CODE_30HZ      = 4'd4;
  localparam logic [CODE_W-1:0] CODE_30HZ_HI   = 4'd12;
  localparam logic [CODE_W-1:0] CODE_50HZ      = 4'd10;
  localparam logic [CODE_W-1:0] CODE_40HZ      = 4'd14;
  localparam logic [CODE_W-1:0] CODE_NO_SIGNAL = 4'd8;
  localparam logic [CODE_W-1:0] CODE_FAULT_BIT = 4'd8;
  localparam logic [CODE_W-1:0] CODE_INVALID   = 4'd15;

  localparam logic [LEN_W-1:0] LEN_NONE = 2'd0;
  localparam logic [LEN_W-1:0] LEN_RES  = 2'd2;

  // Arithmetic constants
  localparam int DUTY_MUL   = 20;
  localparam int RES_SCALE  = 10000;
  localparam int PCT_SCALE  = 100;
  localparam int D_OFFSET   = 500;
  localparam int R_NUM      = 10800000;
  localparam int R_OFFSET   = 1200;
  localparam int PCT_LO     = 47;
  localparam int PCT_HI     = 53;
  localparam logic [RES_W-1:0] RES_MAX = 16'hFFFF;

  typedef enum logic [ACT_W-1:0] {
    ACT_PERIOD = 2'd0,
    ACT_HIGH   = 2'd1,
    ACT_OVF    = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    BAND_NONE,
    BAND_10,
    BAND_20,
    BAND_30,
    BAND_40,
    BAND_50
  } band_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIV_Q,
    ST_DIV_R,
    ST_DIV_PCT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic              start;
    logic [DIVD_W-1:0] dividend;
    logic [VAL_W-1:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DIVD_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [RES_W-1:0]  res;
    logic [TIME_W-1:0] now;
  } frame_t;

  // Frequency band of a period in microseconds
  function automatic band_t band_of(logic [VAL_W-1:0] p);
    logic [31:0] pw;
    band_t       b;
    pw = 32'(p);
    if (pw < 32'd18000)       b = BAND_NONE;
    else if (pw < 32'd22000)  b = BAND_50;
    else if (pw < 32'd24000)  b = BAND_NONE;
    else if (pw < 32'd26000)  b = BAND_40;
    else if (pw < 32'd30000)  b = BAND_NONE;
    else if (pw < 32'd35000)  b = BAND_30;
    else if (pw < 32'd48000)  b = BAND_NONE;
    else if (pw < 32'd52000)  b = BAND_20;
    else if (pw < 32'd90000)  b = BAND_NONE;
    else if (pw < 32'd110000) b = BAND_10;
    else                      b = BAND_NONE;
    return b;
  endfunction

endpackage

// ===== design/insulation_monitor_pwm_decoder_top.sv =====
// Top level of the insulation monitor PWM decoder: sequencer, capture and config registers.
// Depends on ipd_pkg, ipd_div (shared divider) and ipd_out (frame output stage).
//
// Timer events arrive one per input transfer: tuser carries the event kind (period
// capture, high-time capture, counter overflow) and tdata the capture in 4 us ticks plus
// the current time in microseconds. A high-time capture, an ignored event or an overflow
// that only clears the measurements is handled in the idle state. A period capture, or an
// overflow with no period, is decoded by a small sequencer that drives a single shared
// restoring divider; it yields one quotient bit per cycle. No signal, bad duty, 30 Hz and
// invalid periods need no division, 40/50 Hz need one and 10/20 Hz two (duty ratio then
// resistance), or one when the duty ratio alone already saturates the resistance. The
// input is not ready while a decode runs. The frame lands in an output register, so the
// next event is taken while a frame still waits on out_tready; a later frame holds in the
// emit state, with the input not ready, until that register frees up. A frame whose code
// matches the last one sent within holdoff_us is dropped there. Configuration writes are
// accepted in every cycle.
module insulation_monitor_pwm_decoder_top (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // {now_us[63:16], capture_count[15:0]}
  input  logic [ipd_pkg::IN_TDATA_W-1:0]        in_tdata,
  // {action[1:0]}
  input  logic [ipd_pkg::ACT_W-1:0]             in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // {resistance_kohm[50:35], payload_len[34:33], status_code[32:29], frame_id[28:0]}
  output logic [ipd_pkg::OUT_TDATA_W-1:0]       out_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [ipd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [ipd_pkg::CFG_DATA_W-1:0]        cfg_data
);

  ipd_pkg::state_t                   state_r, state_nxt;
  logic [ipd_pkg::VAL_W-1:0]         period_r, period_nxt;
  logic [ipd_pkg::VAL_W-1:0]         high_r, high_nxt;
  logic [ipd_pkg::TIME_W-1:0]        now_r, now_nxt;
  logic [ipd_pkg::CODE_W-1:0]        code_r, code_nxt;
  logic [ipd_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic [ipd_pkg::RES_W-1:0]         res_r, res_nxt;
  logic [ipd_pkg::HOLD_W-1:0]        holdoff_r;
  logic [ipd_pkg::FAULT_W-1:0]       fault_r;

  ipd_pkg::action_t                  action;
  logic [ipd_pkg::CAPTURE_BITS-1:0]  capture;
  ipd_pkg::band_t                    band;
  logic [ipd_pkg::VAL_W+4:0]         h20;
  logic [ipd_pkg::VAL_W+4:0]         ph20;
  logic [ipd_pkg::VAL_W-1:0]         p_minus_h;
  logic                              duty_bad;
  logic [ipd_pkg::CODE_W-1:0]        base_code;
  logic signed [ipd_pkg::R_W-1:0]    r_s;
  logic signed [ipd_pkg::R_W-1:0]    fault_s;
  logic [ipd_pkg::RES_W-1:0]         r_clamped;
  logic [ipd_pkg::DIVD_W-1:0]        quot;

  ipd_pkg::div_req_t                 div_req;
  ipd_pkg::div_rsp_t                 div_rsp;
  ipd_pkg::frame_t                   emit_frame;
  logic                              emit_valid;
  logic                              emit_ready;

  assign action  = ipd_pkg::action_t'(in_tuser);
  assign capture = ipd_pkg::CAPTURE_BITS'(in_tdata[ipd_pkg::CAP_FIELD_W-1:0]);
  assign quot    = div_rsp.quotient;

  // Duty window 5%..95% and the frequency band of the stored period
  assign band      = ipd_pkg::band_of(period_r);
  assign p_minus_h = period_r - high_r;
  assign h20       = (ipd_pkg::VAL_W+5)'(high_r) * (ipd_pkg::VAL_W+5)'(ipd_pkg::DUTY_MUL);
  assign ph20      = (ipd_pkg::VAL_W+5)'(p_minus_h) * (ipd_pkg::VAL_W+5)'(ipd_pkg::DUTY_MUL);
  assign duty_bad  = (h20 < (ipd_pkg::VAL_W+5)'(period_r)) || (high_r >= period_r) ||
                     (ph20 < (ipd_pkg::VAL_W+5)'(period_r));
  assign base_code = (band == ipd_pkg::BAND_20) ? ipd_pkg::CODE_20HZ : ipd_pkg::CODE_10HZ;

  // Resistance from the second quotient: signed for the fault compare, clamped for payload
  assign r_s       = $signed(ipd_pkg::R_W'(quot)) -
                     $signed(ipd_pkg::R_W'(ipd_pkg::R_OFFSET));
  assign fault_s   = $signed({{(ipd_pkg::R_W-ipd_pkg::FAULT_W){1'b0}}, fault_r});
  always_comb begin
    if (r_s[ipd_pkg::R_W-1])
      r_clamped = '0;
    else if (|r_s[ipd_pkg::R_W-2:ipd_pkg::RES_W])
      r_clamped = ipd_pkg::RES_MAX;
    else
      r_clamped = r_s[ipd_pkg::RES_W-1:0];
  end

  // Sequencer
  always_comb begin
    state_nxt        = state_r;
    period_nxt       = period_r;
    high_nxt         = high_r;
    now_nxt          = now_r;
    code_nxt         = code_r;
    len_nxt          = len_r;
    res_nxt          = res_r;
    div_req.start    = 1'b0;
    div_req.dividend = ipd_pkg::DIVD_W'(high_r) * ipd_pkg::DIVD_W'(ipd_pkg::RES_SCALE);
    div_req.divisor  = period_r;
    emit_valid       = 1'b0;
    in_tready        = (state_r == ipd_pkg::ST_IDLE);

    case (state_r)
      ipd_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          case (action)
            ipd_pkg::ACT_PERIOD: begin
              period_nxt = {capture, 2'b00};
              now_nxt    = in_tdata[ipd_pkg::IN_TDATA_W-1:ipd_pkg::CAP_FIELD_W];
              state_nxt  = ipd_pkg::ST_DECODE;
            end
            ipd_pkg::ACT_HIGH: begin
              high_nxt = {capture, 2'b00};
            end
            ipd_pkg::ACT_OVF: begin
              // no period seen: decode a zero period, which reports no signal
              if (period_r == '0) begin
                now_nxt   = in_tdata[ipd_pkg::IN_TDATA_W-1:ipd_pkg::CAP_FIELD_W];
                state_nxt = ipd_pkg::ST_DECODE;
              end
              period_nxt = '0;
              high_nxt   = '0;
            end
            default: begin
            end
          endcase
        end
      end

      ipd_pkg::ST_DECODE: begin
        len_nxt   = ipd_pkg::LEN_NONE;
        res_nxt   = '0;
        code_nxt  = ipd_pkg::CODE_INVALID;
        state_nxt = ipd_pkg::ST_EMIT;
        if (period_r == '0) begin
          code_nxt = ipd_pkg::CODE_NO_SIGNAL;
        end else if (!duty_bad) begin
          case (band)
            ipd_pkg::BAND_10, ipd_pkg::BAND_20: begin
              div_req.start = 1'b1;
              state_nxt     = ipd_pkg::ST_DIV_Q;
            end
            ipd_pkg::BAND_30: begin
              code_nxt = ({high_r, 1'b0} > {1'b0, period_r}) ? ipd_pkg::CODE_30HZ_HI
                                                            : ipd_pkg::CODE_30HZ;
              len_nxt  = ipd_pkg::LEN_RES;
            end
            ipd_pkg::BAND_40, ipd_pkg::BAND_50: begin
              div_req.start    = 1'b1;
              div_req.dividend = ipd_pkg::DIVD_W'(high_r) *
                                 ipd_pkg::DIVD_W'(ipd_pkg::PCT_SCALE);
              state_nxt        = ipd_pkg::ST_DIV_PCT;
            end
            default: begin
            end
          endcase
        end
      end

      ipd_pkg::ST_DIV_Q: begin
        if (div_rsp.done) begin
          if (quot <= ipd_pkg::DIVD_W'(ipd_pkg::D_OFFSET)) begin
            // zero or negative divisor: saturate, never a fault
            code_nxt  = base_code;
            len_nxt   = ipd_pkg::LEN_RES;
            res_nxt   = ipd_pkg::RES_MAX;
            state_nxt = ipd_pkg::ST_EMIT;
          end else begin
            div_req.start    = 1'b1;
            div_req.dividend = ipd_pkg::DIVD_W'(ipd_pkg::R_NUM);
            div_req.divisor  = ipd_pkg::VAL_W'(quot - ipd_pkg::DIVD_W'(ipd_pkg::D_OFFSET));
            state_nxt        = ipd_pkg::ST_DIV_R;
          end
        end
      end

      ipd_pkg::ST_DIV_R: begin
        if (div_rsp.done) begin
          code_nxt  = (r_s < fault_s) ? (base_code | ipd_pkg::CODE_FAULT_BIT) : base_code;
          len_nxt   = ipd_pkg::LEN_RES;
          res_nxt   = r_clamped;
          state_nxt = ipd_pkg::ST_EMIT;
        end
      end

      ipd_pkg::ST_DIV_PCT: begin
        if (div_rsp.done) begin
          if (quot >= ipd_pkg::DIVD_W'(ipd_pkg::PCT_LO) &&
              quot <= ipd_pkg::DIVD_W'(ipd_pkg::PCT_HI)) begin
            code_nxt = (band == ipd_pkg::BAND_40) ? ipd_pkg::CODE_40HZ : ipd_pkg::CODE_50HZ;
            len_nxt  = ipd_pkg::LEN_RES;
          end
          state_nxt = ipd_pkg::ST_EMIT;
        end
      end

      ipd_pkg::ST_EMIT: begin
        // hold until the output register can take the frame
        emit_valid = 1'b1;
        if (emit_ready)
          state_nxt = ipd_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = ipd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ipd_pkg::ST_IDLE;
      period_r <= '0;
      high_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      period_r <= period_nxt;
      high_r   <= high_nxt;
    end
    now_r  <= now_nxt;
    code_r <= code_nxt;
    len_r  <= len_nxt;
    res_r  <= res_nxt;
  end

  // Configuration registers; writes to unknown indexes are dropped
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      holdoff_r <= ipd_pkg::HOLDOFF_RST;
      fault_r   <= ipd_pkg::FAULT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        ipd_pkg::CFG_HOLDOFF: holdoff_r <= cfg_data[ipd_pkg::HOLD_W-1:0];
        ipd_pkg::CFG_FAULT:   fault_r   <= cfg_data[ipd_pkg::FAULT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign emit_frame.code = code_r;
  assign emit_frame.len  = len_r;
  assign emit_frame.res  = res_r;
  assign emit_frame.now  = now_r;

  ipd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  ipd_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_frame (emit_frame),
    .emit_ready (emit_ready),
    .holdoff    (holdoff_r),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== design/ipd_div.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on ipd_pkg for widths and the request and response structs.
module ipd_div (
  input  logic              clk,
  input  logic              rst_n,
  input  ipd_pkg::div_req_t req,
  output ipd_pkg::div_rsp_t rsp
);

  logic                              busy_r, busy_nxt;
  logic                              done_r, done_nxt;
  logic [ipd_pkg::CNT_W-1:0]         cnt_r, cnt_nxt;
  logic [ipd_pkg::VAL_W-1:0]         rem_r, rem_nxt;
  logic [ipd_pkg::DIVD_W-1:0]        quo_r, quo_nxt;
  logic [ipd_pkg::VAL_W-1:0]         dsr_r, dsr_nxt;
  logic [ipd_pkg::VAL_W:0]           trial;
  logic [ipd_pkg::VAL_W:0]           diff;
  logic                              ge;

  assign trial = {rem_r, quo_r[ipd_pkg::DIVD_W-1]};
  assign diff  = trial - {1'b0, dsr_r};
  assign ge    = (trial >= {1'b0, dsr_r});

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = ipd_pkg::CNT_W'(ipd_pkg::DIVD_W - 1);
      rem_nxt  = '0;
      quo_nxt  = req.dividend;
      dsr_nxt  = req.divisor;
    end else if (busy_r) begin
      // shift one dividend bit into the remainder, subtract when it fits
      rem_nxt = ge ? diff[ipd_pkg::VAL_W-1:0] : trial[ipd_pkg::VAL_W-1:0];
      quo_nxt = {quo_r[ipd_pkg::DIVD_W-2:0], ge};
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ===== design/ipd_out.sv =====
// Frame output register with repeat suppression against the last frame sent.
// Depends on ipd_pkg for the frame struct, header base and widths.
module ipd_out (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                emit_valid,
  input  ipd_pkg::frame_t                     emit_frame,
  output logic                                emit_ready,
  input  logic [ipd_pkg::HOLD_W-1:0]          holdoff,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // {resistance_kohm[50:35], payload_len[34:33], status_code[32:29], frame_id[28:0]}
  output logic [ipd_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  logic                                out_valid_r, out_valid_nxt;
  logic [ipd_pkg::OUT_TDATA_W-1:0]     out_data_r, out_data_nxt;
  logic [ipd_pkg::CODE_W-1:0]          last_code_r, last_code_nxt;
  logic [ipd_pkg::TIME_W-1:0]          last_time_r, last_time_nxt;
  logic [ipd_pkg::TIME_W-1:0]          elapsed;
  logic                                drop;
  logic [ipd_pkg::ID_W-1:0]            frame_id;

  assign emit_ready = !out_valid_r || out_tready;
  assign elapsed    = emit_frame.now - last_time_r;
  assign drop       = (emit_frame.code == last_code_r) &&
                      (elapsed < ipd_pkg::TIME_W'(holdoff));
  assign frame_id   = ipd_pkg::HDR_BASE | {13'd0, emit_frame.code, 12'd0};

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    last_code_nxt = last_code_r;
    last_time_nxt = last_time_r;
    if (emit_valid && emit_ready && !drop) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {5'd0, emit_frame.res, emit_frame.len, emit_frame.code, frame_id};
      last_code_nxt = emit_frame.code;
      last_time_nxt = emit_frame.now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_code_r <= ipd_pkg::CODE_NONE;
      last_time_r <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      last_code_r <= last_code_nxt;
      last_time_r <= last_time_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for insulation_monitor_pwm_decoder_top: random and directed timer
// events against a cycle-free frame predictor kept in a small scoreboard class.
// Depends on ipd_pkg and the decoder top level only.
module tb_top;
  import ipd_pkg::*;

  // Field positions inside out_tdata, lowest first
  localparam int CODE_LSB = ID_W;
  localparam int LEN_LSB  = ID_W + CODE_W;
  localparam int RES_LSB  = ID_W + CODE_W + LEN_W;
  // Cycles to let pass after the last expected frame before touching registers
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic [RES_W-1:0]  res;
  } frame_exp_t;

  // Predicts the frames each timer event causes and checks the frames that come out.
  class pwm_frame_scoreboard;
    logic [VAL_W-1:0]   period_meas;
    logic [VAL_W-1:0]   high_us;
    logic [CODE_W-1:0]  last_code;
    logic [TIME_W-1:0]  last_sent;
    logic [HOLD_W-1:0]  holdoff;
    logic [FAULT_W-1:0] fault_lim;
    frame_exp_t         frames_due[$];
    int                 mismatches;

    function new();
      period_meas = '0;
      high_us    = '0;
      last_code  = CODE_NONE;
      last_sent  = '0;
      holdoff    = HOLDOFF_RST;
      fault_lim  = FAULT_RST;
      mismatches = 0;
    endfunction

    function void load_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_HOLDOFF) holdoff = data[HOLD_W-1:0];
      else if (idx == CFG_FAULT) fault_lim = data[FAULT_W-1:0];
    endfunction

    function int pending();
      return frames_due.size();
    endfunction

    // Queue a frame unless it repeats the last one inside the hold-off window
    function void offer(logic [CODE_W-1:0] code, logic [LEN_W-1:0] len,
                        logic [RES_W-1:0] res, logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] since;
      frame_exp_t        f;
      since = now - last_sent;
      if (code == last_code && since < TIME_W'(holdoff)) return;
      last_code = code;
      last_sent = now;
      f.id   = HDR_BASE | (ID_W'(code) << 12);
      f.code = code;
      f.len  = len;
      f.res  = res;
      frames_due.push_back(f);
    endfunction

    function void decode(logic [VAL_W-1:0] p, logic [VAL_W-1:0] h, logic [TIME_W-1:0] now);
      longint unsigned pw, hw, ratio;
      longint          r_kohm;
      int              hz;
      logic [CODE_W-1:0] code;
      logic [RES_W-1:0]  res;
      pw = 64'(p);
      hw = 64'(h);
      if (pw == 0) begin
        offer(CODE_NO_SIGNAL, LEN_NONE, '0, now);
        return;
      end
      // duty outside 5..95 percent
      if (hw * DUTY_MUL < pw || hw >= pw || (pw - hw) * DUTY_MUL < pw) begin
        offer(CODE_INVALID, LEN_NONE, '0, now);
        return;
      end
      if (pw >= 18000 && pw < 22000) hz = 50;
      else if (pw >= 24000 && pw < 26000) hz = 40;
      else if (pw >= 30000 && pw < 35000) hz = 30;
      else if (pw >= 48000 && pw < 52000) hz = 20;
      else if (pw >= 90000 && pw < 110000) hz = 10;
      else hz = 0;
      case (hz)
        10, 20: begin
          code  = (hz == 20) ? CODE_20HZ : CODE_10HZ;
          ratio = (RES_SCALE * hw) / pw;
          if (ratio <= D_OFFSET) r_kohm = 65535;
          else r_kohm = longint'(R_NUM / (ratio - D_OFFSET)) - R_OFFSET;
          if (r_kohm < longint'(fault_lim)) code = code | CODE_FAULT_BIT;
          if (r_kohm < 0) res = '0;
          else if (r_kohm > 65535) res = RES_MAX;
          else res = RES_W'(r_kohm);
          offer(code, LEN_RES, res, now);
        end
        30: offer((hw * 2 > pw) ? CODE_30HZ_HI : CODE_30HZ, LEN_RES, '0, now);
        40, 50: begin
          ratio = (PCT_SCALE * hw) / pw;
          if (ratio >= PCT_LO && ratio <= PCT_HI)
            offer((hz == 40) ? CODE_40HZ : CODE_50HZ, LEN_RES, '0, now);
          else
            offer(CODE_INVALID, LEN_NONE, '0, now);
        end
        default: offer(CODE_INVALID, LEN_NONE, '0, now);
      endcase
    endfunction

    function void take_event(action_t act, logic [CAPTURE_BITS-1:0] ticks,
                             logic [TIME_W-1:0] now);
      case (act)
        ACT_PERIOD: begin
          period_meas = VAL_W'(ticks) << 2;
          decode(period_meas, high_us, now);
        end
        ACT_HIGH: high_us = VAL_W'(ticks) << 2;
        ACT_OVF: begin
          if (period_meas == '0) decode('0, '0, now);
          period_meas = '0;
          high_us   = '0;
        end
        default: ;
      endcase
    endfunction

    function void compare_field(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void match_frame(logic [OUT_TDATA_W-1:0] td);
      frame_exp_t want;
      if (frames_due.size() == 0) begin
        $display("%0t: frame with no expectation, expected none, actual %h", $time, td);
        mismatches++;
        return;
      end
      want = frames_due.pop_front();
      compare_field("frame_id", 64'(want.id), 64'(td[ID_W-1:0]));
      compare_field("status_code", 64'(want.code), 64'(td[CODE_LSB +: CODE_W]));
      compare_field("payload_len", 64'(want.len), 64'(td[LEN_LSB +: LEN_W]));
      compare_field("resistance_kohm", 64'(want.res), 64'(td[RES_LSB +: RES_W]));
    endfunction
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // {now_us[63:16], capture_count[15:0]}
  logic [ACT_W-1:0]       in_tuser;   // {action[1:0]}
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // {resistance_kohm[50:35], payload_len[34:33], status_code[32:29], frame_id[28:0]}
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  pwm_frame_scoreboard board = new();
  bit                  idle_en = 1'b1;
  int unsigned         stall_left = 0;
  logic [TIME_W-1:0]   clock_us;

  insulation_monitor_pwm_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Frame sink: check every transfer, drop ready in random bursts while idling is on
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.match_frame(out_tdata);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Hold one event on the input until it transfers; sometimes idle first
  task automatic send_event(action_t act, logic [CAPTURE_BITS-1:0] ticks,
                            logic [TIME_W-1:0] now);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {now, ticks};
    in_tuser  <= act;
    do @(posedge clk); while (!in_tready);
    board.take_event(act, ticks, now);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    board.load_reg(idx, data);
  endtask

  task automatic program_regs(logic [CFG_DATA_W-1:0] hold, logic [CFG_DATA_W-1:0] fault);
    write_reg(CFG_HOLDOFF, hold);
    write_reg(CFG_FAULT, fault);
    cfg_valid <= 1'b0;
  endtask

  // Drain: release the input, wait for every expected frame, then let the decoder settle
  task automatic drain();
    int guard;
    guard = 0;
    in_tvalid <= 1'b0;
    while (board.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Advance the wall clock: mostly PWM-like steps, sometimes jumps, reversals and wraps
  function automatic logic [TIME_W-1:0] step_clock();
    case ($urandom_range(0, 19))
      0: clock_us = TIME_W'({$urandom, $urandom});
      1: clock_us = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 200000));
      2: clock_us = clock_us - TIME_W'($urandom_range(1, 5000));
      3, 4: clock_us = clock_us + TIME_W'($urandom_range(0, 3000));
      default: clock_us = clock_us + TIME_W'($urandom_range(15000, 110000));
    endcase
    return clock_us;
  endfunction

  function automatic logic [TIME_W-1:0] later(int unsigned delta);
    clock_us = clock_us + TIME_W'(delta);
    return clock_us;
  endfunction

  // Period in ticks: mostly inside a band, some at band edges, some anywhere
  function automatic logic [CAPTURE_BITS-1:0] pick_period();
    int unsigned edges[10] = '{4500, 5500, 6000, 6500, 7500, 8750, 12000, 13000,
                               22500, 27500};
    case ($urandom_range(0, 11))
      0, 1: return CAPTURE_BITS'($urandom_range(22500, 27499));
      2, 3: return CAPTURE_BITS'($urandom_range(12000, 12999));
      4:    return CAPTURE_BITS'($urandom_range(7500, 8749));
      5, 6: return CAPTURE_BITS'($urandom_range(6000, 6499));
      7, 8: return CAPTURE_BITS'($urandom_range(4500, 5499));
      9:    return CAPTURE_BITS'(edges[$urandom_range(0, 9)] - $urandom_range(0, 1));
      default: return CAPTURE_BITS'($urandom);
    endcase
  endfunction

  // High time in ticks for a period: near 50 %, near either duty limit, or anywhere
  function automatic logic [CAPTURE_BITS-1:0] pick_high(logic [CAPTURE_BITS-1:0] p);
    int unsigned permyriad;
    case ($urandom_range(0, 5))
      0: permyriad = $urandom_range(4600, 5400);
      1: permyriad = $urandom_range(450, 560);
      2: permyriad = $urandom_range(9400, 9560);
      3: return CAPTURE_BITS'($urandom);
      default: permyriad = $urandom_range(500, 9500);
    endcase
    return CAPTURE_BITS'((longint'(p) * permyriad) / 10000);
  endfunction

  task automatic run_phase(int unsigned n_items);
    int unsigned      done;
    int unsigned      pick;
    logic [CAPTURE_BITS-1:0] p_ticks;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        p_ticks = pick_period();
        send_event(ACT_HIGH, pick_high(p_ticks), step_clock());
        send_event(ACT_PERIOD, p_ticks, step_clock());
        done += 2;
      end else if (pick < 80) begin
        send_event(ACT_PERIOD, pick_period(), step_clock());
        done++;
      end else if (pick < 89) begin
        send_event(ACT_OVF, CAPTURE_BITS'($urandom), step_clock());
        done++;
      end else if (pick < 93) begin
        // unused action: ignored, not counted
        send_event(ACT_NONE, CAPTURE_BITS'($urandom), step_clock());
      end else begin
        send_event(ACT_HIGH, CAPTURE_BITS'($urandom), step_clock());
        done++;
      end
    end
  endtask

  initial begin
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= ACT_PERIOD;
    cfg_valid <= 1'b0;
    cfg_index <= CFG_HOLDOFF;
    cfg_data  <= '0;
    rst_n     <= 1'b0;
    clock_us   = TIME_W'(1000);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset register values
    send_event(ACT_OVF, 16'h0000, clock_us);              // no signal after reset
    send_event(ACT_OVF, 16'hFFFF, later(10));             // same code inside window: dropped
    send_event(ACT_NONE, 16'hA5A5, later(10));            // unused action
    send_event(ACT_PERIOD, 16'h0000, later(95000));       // zero period, window expired
    send_event(ACT_HIGH, 16'hFFFF, later(200000));
    send_event(ACT_PERIOD, 16'hFFFF, later(200000));      // high time equals period
    send_event(ACT_HIGH, 16'd1250, later(200000));
    send_event(ACT_PERIOD, 16'd25000, later(200000));     // 10 Hz, zero divisor
    send_event(ACT_HIGH, 16'd23750, later(200000));
    send_event(ACT_PERIOD, 16'd25000, later(200000));     // 10 Hz, zero resistance, fault
    send_event(ACT_HIGH, 16'd1253, later(200000));
    send_event(ACT_PERIOD, 16'd25000, later(200000));     // resistance saturates
    send_event(ACT_HIGH, 16'd6250, later(200000));
    send_event(ACT_PERIOD, 16'd12500, later(200000));     // 20 Hz
    send_event(ACT_HIGH, 16'd4000, later(200000));
    send_event(ACT_PERIOD, 16'd8000, later(200000));      // 30 Hz, exactly half
    send_event(ACT_HIGH, 16'd5000, later(200000));
    send_event(ACT_PERIOD, 16'd8000, later(200000));      // 30 Hz, high half
    send_event(ACT_HIGH, 16'd3125, later(200000));
    send_event(ACT_PERIOD, 16'd6250, later(200000));      // 40 Hz
    send_event(ACT_HIGH, 16'd2350, later(200000));
    send_event(ACT_PERIOD, 16'd5000, later(200000));      // 50 Hz, 47 percent
    send_event(ACT_HIGH, 16'd2700, later(200000));
    send_event(ACT_PERIOD, 16'd5000, later(200000));      // 50 Hz, 54 percent: invalid
    send_event(ACT_HIGH, 16'd5000, later(200000));
    send_event(ACT_PERIOD, 16'd10000, later(200000));     // good duty, no band
    send_event(ACT_OVF, 16'h1234, later(200000));         // period set: clear only
    clock_us = {TIME_W{1'b1}} - TIME_W'(15);
    send_event(ACT_OVF, 16'h0000, clock_us);              // no signal before wrap
    clock_us = TIME_W'(16);
    send_event(ACT_OVF, 16'h0000, clock_us);              // across wrap: dropped
    drain();

    program_regs('0, '0);
    run_phase(100);
    drain();

    program_regs({CFG_DATA_W{1'b1}}, CFG_DATA_W'(16'hFFFF));
    run_phase(100);
    drain();

    program_regs(CFG_DATA_W'($urandom_range(0, 200000)),
                 {CFG_DATA_W'($urandom_range(0, 15)) << FAULT_W} |
                 CFG_DATA_W'($urandom_range(0, 2000)));
    run_phase(100);
    drain();

    // last stretch with both sides running flat out
    program_regs(CFG_DATA_W'(HOLDOFF_RST), CFG_DATA_W'(FAULT_RST));
    idle_en = 1'b0;
    run_phase(100);
    drain();

    if (board.pending() != 0) begin
      $display("%0t: frames never seen, expected %0d more, actual 0",
               $time, board.pending());
      board.mismatches++;
    end
    if (board.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
